### rtl/core/vvc_access_unit_splitter_core_defines.svh
// Assertion macros used by the back end of the access unit splitter RTL.
`ifndef VVC_ACCESS_UNIT_SPLITTER_CORE_DEFINES_SVH
`define VVC_ACCESS_UNIT_SPLITTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define VAUS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vvc_aus: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define VAUS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vvc_aus: next-cycle check failed");

`endif

### rtl/core/vvc_aus_pkg.sv
// Package with the types, codes and constants of the access unit splitter.
`default_nettype none
package vvc_aus_pkg;

  typedef enum logic [1:0] {
    OP_NAL     = 2'd0,
    OP_FLUSH   = 2'd1,
    OP_RESET   = 2'd2,
    OP_UNKNOWN = 2'd3
  } op_code_t;

  typedef enum logic [2:0] {
    ITEM_IGNORE,
    ITEM_FORBID,
    ITEM_NAL,
    ITEM_FLUSH,
    ITEM_RESET
  } item_kind_t;

  // NAL type classes as seen by the boundary logic.
  typedef enum logic [2:0] {
    NCLS_SLICE,
    NCLS_NEW_IF_SLICE,
    NCLS_NEW,
    NCLS_SUFFIX,
    NCLS_MAYBE
  } nal_class_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_EMIT    = 2'd1,
    ACT_DISCARD = 2'd2
  } unit_action_t;

  typedef enum logic [1:0] {
    ROUTE_DROP   = 2'd0,
    ROUTE_APPEND = 2'd1,
    ROUTE_HELD   = 2'd2
  } nal_route_t;

  // NAL unit type codes.
  localparam logic [4:0] NUT_VCL_LAST   = 5'd11;
  localparam logic [4:0] NUT_OPI        = 5'd12;
  localparam logic [4:0] NUT_SPS        = 5'd15;
  localparam logic [4:0] NUT_PPS        = 5'd16;
  localparam logic [4:0] NUT_SUFFIX_APS = 5'd18;
  localparam logic [4:0] NUT_PH         = 5'd19;
  localparam logic [4:0] NUT_AUD        = 5'd20;
  localparam logic [4:0] NUT_EOS        = 5'd21;
  localparam logic [4:0] NUT_EOB        = 5'd22;
  localparam logic [4:0] NUT_SUFFIX_SEI = 5'd24;

  // Header bit positions.
  localparam int FORBIDDEN_BIT   = 7;
  localparam int PH_IN_SLICE_BIT = 7;

  // Temporal id at or above which a unit carries the B mark.
  localparam logic signed [3:0] TID_B_MIN = 4'sd2;

  typedef struct packed {
    item_kind_t        kind;
    nal_class_t        ncls;
    logic              is_sps;
    logic              is_pps;
    logic              ph_in_slice;
    logic [5:0]        layer;
    logic signed [3:0] tid;
  } item_cls_t;

  typedef struct packed {
    unit_action_t unit_action;
    logic         unit_p_mark;
    logic         unit_b_mark;
    logic         pending_merged;
    nal_route_t   nal_route;
    logic         nal_is_slice;
  } result_t;

endpackage
`default_nettype wire

### rtl/core/vvc_aus_ifs.sv
// Valid/ready channel interfaces for NAL items and splitter results.
`default_nettype none
interface vvc_aus_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic       too_short;
  logic [7:0] header_byte0;
  logic [7:0] header_byte1;
  logic [7:0] slice_byte0;

  modport source (output valid, operation, too_short, header_byte0, header_byte1,
                  slice_byte0, input ready);
  modport sink (input valid, operation, too_short, header_byte0, header_byte1,
                slice_byte0, output ready);
endinterface

interface vvc_aus_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] unit_action;
  logic       unit_p_mark;
  logic       unit_b_mark;
  logic       pending_merged;
  logic [1:0] nal_route;
  logic       nal_is_slice;

  modport source (output valid, unit_action, unit_p_mark, unit_b_mark, pending_merged,
                  nal_route, nal_is_slice, input ready);
  modport sink (input valid, unit_action, unit_p_mark, unit_b_mark, pending_merged,
                nal_route, nal_is_slice, output ready);
endinterface
`default_nettype wire

### rtl/core/vvc_aus_front.sv
// Front end: accepts NAL transactions and classifies their headers.
`default_nettype none
module vvc_aus_front (
  vvc_aus_in_if.sink             in_chan,
  input  logic                   full_i,
  output logic                   push_o,
  output vvc_aus_pkg::item_cls_t cls_o
);
  import vvc_aus_pkg::*;

  logic [4:0] nal_type;

  assign in_chan.ready = !full_i;
  assign push_o        = in_chan.valid && !full_i;
  assign nal_type      = in_chan.header_byte1[7:3];

  always_comb begin
    cls_o             = '0;
    cls_o.layer       = in_chan.header_byte0[5:0];
    cls_o.tid         = $signed({1'b0, in_chan.header_byte1[2:0]}) - 4'sd1;
    cls_o.ph_in_slice = in_chan.slice_byte0[PH_IN_SLICE_BIT];
    cls_o.is_sps      = (nal_type == NUT_SPS);
    cls_o.is_pps      = (nal_type == NUT_PPS);

    if (nal_type <= NUT_VCL_LAST) begin
      cls_o.ncls = NCLS_SLICE;
    end else if ((nal_type >= NUT_OPI && nal_type <= NUT_PPS) ||
                 nal_type == NUT_PH || nal_type == NUT_AUD) begin
      cls_o.ncls = NCLS_NEW_IF_SLICE;
    end else if (nal_type == NUT_EOS || nal_type == NUT_EOB) begin
      cls_o.ncls = NCLS_NEW;
    end else if (nal_type == NUT_SUFFIX_APS || nal_type == NUT_SUFFIX_SEI) begin
      cls_o.ncls = NCLS_SUFFIX;
    end else begin
      cls_o.ncls = NCLS_MAYBE;
    end

    case (op_code_t'(in_chan.operation))
      OP_NAL: begin
        if (in_chan.too_short) begin
          cls_o.kind = ITEM_IGNORE;
        end else if (in_chan.header_byte0[FORBIDDEN_BIT]) begin
          cls_o.kind = ITEM_FORBID;
        end else begin
          cls_o.kind = ITEM_NAL;
        end
      end
      OP_FLUSH: cls_o.kind = ITEM_FLUSH;
      OP_RESET: cls_o.kind = ITEM_RESET;
      default:  cls_o.kind = ITEM_IGNORE;
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/vvc_aus_queue.sv
// Two-entry queue of classified items between front and back end.
`default_nettype none
module vvc_aus_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push_i,
  input  vvc_aus_pkg::item_cls_t data_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output logic                   valid_o,
  output vvc_aus_pkg::item_cls_t data_o
);
  import vvc_aus_pkg::*;

  item_cls_t  entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full_o  = (count_r == 2'd2);
  assign valid_o = (count_r != 2'd0);
  assign data_o  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_i;
    rd_ptr_nxt = rd_ptr_r ^ pop_i;
    count_nxt  = count_r + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      entry_r[wr_ptr_r] <= data_i;
    end
  end

endmodule
`default_nettype wire

### rtl/core/vvc_aus_back.sv
// Back end: stream state, access unit decisions and the result register.
`default_nettype none
`include "vvc_access_unit_splitter_core_defines.svh"
module vvc_aus_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid_i,
  input  vvc_aus_pkg::item_cls_t q_data_i,
  output logic                   pop_o,
  vvc_aus_out_if.source          out_chan
);
  import vvc_aus_pkg::*;

  logic              slice_in_pic_r, slice_in_pic_nxt;
  logic              seen_sps_r, seen_sps_nxt;
  logic              seen_pps_r, seen_pps_nxt;
  logic              stream_ready_r, stream_ready_nxt;
  logic signed [3:0] last_tid_r, last_tid_nxt;
  logic              base_valid_r, base_valid_nxt;
  logic [5:0]        base_layer_r, base_layer_nxt;
  logic              unit_open_r, unit_open_nxt;
  logic              head_slice_r, head_slice_nxt;
  logic              pending_r, pending_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           result_r, res;

  logic is_new, first_slice, maybe_new, ready_now;

  assign pop_o = q_valid_i && (!out_valid_r || out_chan.ready);

  always_comb begin
    slice_in_pic_nxt = slice_in_pic_r;
    seen_sps_nxt     = seen_sps_r;
    seen_pps_nxt     = seen_pps_r;
    stream_ready_nxt = stream_ready_r;
    last_tid_nxt     = last_tid_r;
    base_valid_nxt   = base_valid_r;
    base_layer_nxt   = base_layer_r;
    unit_open_nxt    = unit_open_r;
    head_slice_nxt   = head_slice_r;
    pending_nxt      = pending_r;
    res              = result_t'('0);
    is_new           = 1'b0;
    first_slice      = 1'b0;
    maybe_new        = 1'b0;
    ready_now        = stream_ready_r;

    if (pop_o) begin
      case (q_data_i.kind)
        ITEM_FLUSH, ITEM_RESET: begin
          // Held units join first; if nothing was open they open a non-slice unit.
          res.pending_merged = pending_r;
          if (unit_open_r || pending_r) begin
            if (q_data_i.kind == ITEM_FLUSH && stream_ready_r) begin
              res.unit_action = ACT_EMIT;
              res.unit_p_mark = unit_open_r && head_slice_r;
            end else begin
              res.unit_action = ACT_DISCARD;
            end
          end
          unit_open_nxt  = 1'b0;
          head_slice_nxt = 1'b0;
          pending_nxt    = 1'b0;
          if (q_data_i.kind == ITEM_RESET) begin
            stream_ready_nxt = 1'b0;
            slice_in_pic_nxt = 1'b0;
            last_tid_nxt     = '0;
            seen_pps_nxt     = 1'b0;
            seen_sps_nxt     = 1'b0;
          end
        end
        ITEM_FORBID: begin
          if (unit_open_r) begin
            res.unit_action = ACT_DISCARD;
          end
          unit_open_nxt  = 1'b0;
          head_slice_nxt = 1'b0;
        end
        ITEM_NAL: begin
          case (q_data_i.ncls)
            NCLS_SLICE: begin
              res.nal_is_slice = 1'b1;
              first_slice      = q_data_i.ph_in_slice || !slice_in_pic_r;
              is_new           = slice_in_pic_r && first_slice;
              slice_in_pic_nxt = 1'b1;
            end
            NCLS_NEW_IF_SLICE: is_new    = slice_in_pic_r;
            NCLS_NEW:          is_new    = 1'b1;
            NCLS_SUFFIX:       is_new    = 1'b0;
            NCLS_MAYBE:        maybe_new = slice_in_pic_r;
            default:           is_new    = 1'b0;
          endcase

          seen_pps_nxt = seen_pps_r || q_data_i.is_pps;
          seen_sps_nxt = seen_sps_r || q_data_i.is_sps;

          if (is_new) begin
            ready_now        = stream_ready_r || (seen_pps_nxt && seen_sps_nxt);
            stream_ready_nxt = ready_now;
            if (unit_open_r) begin
              if (!base_valid_r || q_data_i.layer < base_layer_r) begin
                base_valid_nxt = 1'b1;
                base_layer_nxt = q_data_i.layer;
              end
              if (ready_now) begin
                res.unit_action = ACT_EMIT;
                res.unit_p_mark = head_slice_r || (last_tid_r < TID_B_MIN);
                res.unit_b_mark = (last_tid_r >= TID_B_MIN);
              end else begin
                res.unit_action = ACT_DISCARD;
              end
            end
            unit_open_nxt    = 1'b0;
            head_slice_nxt   = 1'b0;
            slice_in_pic_nxt = first_slice;
          end

          last_tid_nxt = q_data_i.tid;

          if (maybe_new) begin
            pending_nxt   = 1'b1;
            res.nal_route = ROUTE_HELD;
          end else begin
            res.pending_merged = pending_r;
            pending_nxt        = 1'b0;
            if (!unit_open_nxt) begin
              unit_open_nxt  = 1'b1;
              head_slice_nxt = !pending_r && res.nal_is_slice;
            end
            res.nal_route = ROUTE_APPEND;
          end
        end
        default: ;
      endcase
    end

    out_valid_nxt = pop_o || (out_valid_r && !out_chan.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_in_pic_r <= 1'b0;
      seen_sps_r     <= 1'b0;
      seen_pps_r     <= 1'b0;
      stream_ready_r <= 1'b0;
      last_tid_r     <= '0;
      base_valid_r   <= 1'b0;
      unit_open_r    <= 1'b0;
      head_slice_r   <= 1'b0;
      pending_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      slice_in_pic_r <= slice_in_pic_nxt;
      seen_sps_r     <= seen_sps_nxt;
      seen_pps_r     <= seen_pps_nxt;
      stream_ready_r <= stream_ready_nxt;
      last_tid_r     <= last_tid_nxt;
      base_valid_r   <= base_valid_nxt;
      unit_open_r    <= unit_open_nxt;
      head_slice_r   <= head_slice_nxt;
      pending_r      <= pending_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_layer_r <= base_layer_nxt;
    if (pop_o) begin
      result_r <= res;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.unit_action    = result_r.unit_action;
  assign out_chan.unit_p_mark    = result_r.unit_p_mark;
  assign out_chan.unit_b_mark    = result_r.unit_b_mark;
  assign out_chan.pending_merged = result_r.pending_merged;
  assign out_chan.nal_route      = result_r.nal_route;
  assign out_chan.nal_is_slice   = result_r.nal_is_slice;

  `VAUS_ASSERT_SAME(a_head_needs_open, head_slice_r, unit_open_r)
  `VAUS_ASSERT_SAME(a_merge_needs_pending, pop_o && res.pending_merged, pending_r)
  `VAUS_ASSERT_NEXT(a_held_sets_pending, pop_o && res.nal_route == ROUTE_HELD, pending_r)
  `VAUS_ASSERT_NEXT(a_append_opens_unit, pop_o && res.nal_route == ROUTE_APPEND, unit_open_r)
  `VAUS_ASSERT_NEXT(a_emit_needs_ready, pop_o && res.unit_action == ACT_EMIT, stream_ready_r)

endmodule
`default_nettype wire

### rtl/core/vvc_access_unit_splitter_core.sv
// Data path: each transaction is registered in the queue, then in the result register.
// Throughput: one NAL transaction per cycle while out_chan.ready is high, set by the
// state update in the back end; a two-entry queue and a result register decouple
// the two sides. Reset: synchronous on rst_n low; it empties the queue and the result
// register, returns the stream state to its initial values and marks the base layer invalid.
`default_nettype none
module vvc_access_unit_splitter_core (
  input  logic          clk,
  input  logic          rst_n,
  vvc_aus_in_if.sink    in_chan,
  vvc_aus_out_if.source out_chan
);
  import vvc_aus_pkg::*;

  // Classified item from the front end, pushed into the queue.
  item_cls_t front_cls;
  logic      front_push;
  logic      queue_full;

  // Head of the queue as seen by the back end.
  item_cls_t queue_head;
  logic      queue_valid;
  logic      back_pop;

  // The front end decodes the operation and NAL header of each transaction
  // into an item kind and a NAL type class. It holds no state.
  vvc_aus_front u_front (
    .in_chan (in_chan),
    .full_i  (queue_full),
    .push_o  (front_push),
    .cls_o   (front_cls)
  );

  // The queue lets the front keep accepting while the back end waits on a
  // stalled result channel.
  vvc_aus_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (front_push),
    .data_i  (front_cls),
    .full_o  (queue_full),
    .pop_i   (back_pop),
    .valid_o (queue_valid),
    .data_o  (queue_head)
  );

  // The back end keeps the picture and parameter set tracking, decides
  // whether the open access unit is emitted or discarded, and registers
  // one result transaction per item.
  vvc_aus_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid_i (queue_valid),
    .q_data_i  (queue_head),
    .pop_o     (back_pop),
    .out_chan  (out_chan)
  );

endmodule
`default_nettype wire

### test/tb.sv
// Self-checking testbench for the VVC access unit splitter core.
`timescale 1ns / 1ps

module tb;
  import vvc_aus_pkg::*;

  // NAL unit type codes that the package does not name.
  localparam logic [4:0] NUT_TRAIL      = 5'd0;
  localparam logic [4:0] NUT_DCI        = 5'd13;
  localparam logic [4:0] NUT_VPS        = 5'd14;
  localparam logic [4:0] NUT_PREFIX_APS = 5'd17;
  localparam logic [4:0] NUT_PREFIX_SEI = 5'd23;
  localparam logic [4:0] NUT_RSV_FIRST  = 5'd25;
  localparam logic [4:0] NUT_RSV_LAST   = 5'd31;

  localparam int ITEM_TARGET  = 1350;
  localparam int TAIL_ITEMS   = 200;  // final stretch that runs without any idling
  localparam int LONG_HOLD    = 60;   // cycles the result side stays stalled once
  localparam int HOLD_AT_ITEM = 300;
  localparam int DRAIN_CYCLES = 8;

  // One row of stimulus. When typed is set, want holds the expected result.
  typedef struct packed {
    op_code_t   op;
    logic       short_f;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] sb;
    logic       typed;
    result_t    want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  vvc_aus_in_if  in_chan ();
  vvc_aus_out_if out_chan ();

  vvc_access_unit_splitter_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Whatever happens, the run ends well past the slowest correct finish.
  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  // Shadow of the splitter's stream state, advanced once per accepted transaction.
  logic              in_pic        = 1'b0;
  logic              have_sps      = 1'b0;
  logic              have_pps      = 1'b0;
  logic              stream_ok     = 1'b0;
  logic signed [3:0] prev_tid      = 4'sd0;
  int                base_lyr      = -1;
  logic              au_open       = 1'b0;
  logic              au_head_slice = 1'b0;
  logic              held          = 1'b0;

  result_t expected_decisions[$];
  int      mismatch_count  = 0;
  int      items_counted   = 0;
  int      units_emitted   = 0;
  int      units_discarded = 0;
  int      nals_held       = 0;
  int      src_idle_pct    = 15;
  logic    quiet_tail      = 1'b0;
  logic    long_hold_done  = 1'b0;

  // Held NAL units move into the current unit; a unit opens for them if none is open.
  function automatic logic merge_held();
    if (!held) return 1'b0;
    if (!au_open) begin
      au_open       = 1'b1;
      au_head_slice = 1'b0;
    end
    held = 1'b0;
    return 1'b1;
  endfunction

  // Works out the splitter's decision for one transaction and updates the shadow state.
  function automatic result_t predict_au_decision(input stim_row_t r);
    result_t           res;
    logic [4:0]        nut;
    logic signed [3:0] tid;
    int                lay;
    logic              new_pic;
    logic              first_sl;
    logic              maybe_pic;
    res       = '0;
    nut       = r.b1[7:3];
    tid       = $signed({1'b0, r.b1[2:0]}) - 4'sd1;
    lay       = int'(r.b0[5:0]);
    new_pic   = 1'b0;
    first_sl  = 1'b0;
    maybe_pic = 1'b0;
    case (r.op)
      OP_FLUSH, OP_RESET: begin
        // Held NAL units join the unit first; then the unit closes.
        res.pending_merged = merge_held();
        if (au_open) begin
          if (r.op == OP_FLUSH && stream_ok) begin
            res.unit_action = ACT_EMIT;
            res.unit_p_mark = au_head_slice;
          end else begin
            res.unit_action = ACT_DISCARD;
          end
        end
        au_open       = 1'b0;
        au_head_slice = 1'b0;
        if (r.op == OP_RESET) begin
          // The base layer survives a stream reset.
          stream_ok = 1'b0;
          in_pic    = 1'b0;
          prev_tid  = 4'sd0;
          have_pps  = 1'b0;
          have_sps  = 1'b0;
        end
      end
      OP_NAL: begin
        if (r.short_f) begin
          // Too short to parse: dropped, no state touched.
        end else if (r.b0[FORBIDDEN_BIT]) begin
          // A corrupt header throws away the open unit but leaves held units alone.
          if (au_open) res.unit_action = ACT_DISCARD;
          au_open       = 1'b0;
          au_head_slice = 1'b0;
        end else begin
          if (nut <= NUT_VCL_LAST) begin
            res.nal_is_slice = 1'b1;
            first_sl = r.sb[PH_IN_SLICE_BIT] || !in_pic;
            new_pic  = in_pic && first_sl;
            in_pic   = 1'b1;
          end else if ((nut >= NUT_OPI && nut <= NUT_PPS) || nut == NUT_PH || nut == NUT_AUD) begin
            new_pic = in_pic;
          end else if (nut == NUT_EOS || nut == NUT_EOB) begin
            new_pic = 1'b1;
          end else if (nut == NUT_SUFFIX_APS || nut == NUT_SUFFIX_SEI) begin
            // Suffix units always stay with the current unit.
          end else begin
            maybe_pic = in_pic;
          end
          if (nut == NUT_PPS) have_pps = 1'b1;
          if (nut == NUT_SPS) have_sps = 1'b1;
          if (new_pic) begin
            if (have_pps && have_sps) stream_ok = 1'b1;
            if (au_open) begin
              if (base_lyr < 0 || lay < base_lyr) base_lyr = lay;
              if (stream_ok) begin
                res.unit_action = ACT_EMIT;
                res.unit_p_mark = au_head_slice || (prev_tid < TID_B_MIN);
                res.unit_b_mark = (prev_tid >= TID_B_MIN);
              end else begin
                res.unit_action = ACT_DISCARD;
              end
              au_open       = 1'b0;
              au_head_slice = 1'b0;
            end
            in_pic = first_sl;
          end
          prev_tid = tid;
          if (maybe_pic) begin
            held          = 1'b1;
            res.nal_route = ROUTE_HELD;
          end else begin
            res.pending_merged = merge_held();
            if (!au_open) begin
              au_open       = 1'b1;
              au_head_slice = res.nal_is_slice;
            end
            res.nal_route = ROUTE_APPEND;
          end
        end
      end
      default: begin
        // An unknown operation leaves everything as it is.
      end
    endcase
    return res;
  endfunction

  function automatic stim_row_t mk_row(input op_code_t op, input logic short_f,
                                       input logic [7:0] b0, input logic [7:0] b1,
                                       input logic [7:0] sb, input logic typed,
                                       input result_t want);
    stim_row_t r;
    r.op      = op;
    r.short_f = short_f;
    r.b0      = b0;
    r.b1      = b1;
    r.sb      = sb;
    r.typed   = typed;
    r.want    = want;
    return r;
  endfunction

  // Offers one transaction and holds it until the core takes it. The expectation is
  // recorded at the accepting edge, so the store stays in acceptance order.
  task automatic offer_item(input stim_row_t r);
    result_t predicted;
    in_chan.valid        <= 1'b1;
    in_chan.operation    <= r.op;
    in_chan.too_short    <= r.short_f;
    in_chan.header_byte0 <= r.b0;
    in_chan.header_byte1 <= r.b1;
    in_chan.slice_byte0  <= r.sb;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    predicted = predict_au_decision(r);
    expected_decisions.push_back(r.typed ? r.want : predicted);
    if (predicted.unit_action == ACT_EMIT) units_emitted++;
    if (predicted.unit_action == ACT_DISCARD) units_discarded++;
    if (predicted.nal_route == ROUTE_HELD) nals_held++;
    // Unknown operations and short fragments do nothing, so they do not count.
    if (r.op == OP_FLUSH || r.op == OP_RESET || (r.op == OP_NAL && !r.short_f))
      items_counted++;
    if (items_counted >= ITEM_TARGET - TAIL_ITEMS) quiet_tail = 1'b1;
    // Random gaps on the input side; valid stays high when the next item follows at once.
    if (!quiet_tail && $urandom_range(0, 99) < src_idle_pct) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic send_nal(input logic [4:0] nut, input logic [2:0] tp1,
                          input logic [5:0] lay, input logic [7:0] sb);
    offer_item(mk_row(OP_NAL, 1'b0, {2'b00, lay}, {nut, tp1}, sb, 1'b0, '0));
  endtask

  // Flush or reset, with junk in the header fields, which the core must ignore.
  task automatic send_op(input op_code_t op);
    offer_item(mk_row(op, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      1'b0, '0));
  endtask

  // Fully random transaction: forbidden bit, reserved bit, short fragments, any op.
  task automatic send_noise();
    op_code_t op;
    op = ($urandom_range(0, 3) != 0) ? OP_NAL : op_code_t'($urandom_range(0, 3));
    offer_item(mk_row(op, ($urandom_range(0, 3) == 0), 8'($urandom), 8'($urandom),
                      8'($urandom), 1'b0, '0));
  endtask

  // One mostly well-formed picture: optional AUD, parameter sets, picture header and prefix
  // units, one to four slices, optional suffix units, sometimes a stream event after.
  task automatic send_random_picture();
    logic [2:0] tp1;
    logic [5:0] lay;
    logic [7:0] sb;
    int         n_sl;
    int         k;
    tp1 = ($urandom_range(0, 15) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
    lay = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 1));
    src_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 15;
    if ($urandom_range(0, 3) == 0) send_nal(NUT_AUD, tp1, lay, 8'($urandom));
    if ($urandom_range(0, 5) == 0) send_nal(NUT_VPS, tp1, lay, 8'($urandom));
    if ($urandom_range(0, 3) == 0) send_nal(NUT_SPS, tp1, lay, 8'($urandom));
    if ($urandom_range(0, 3) == 0) send_nal(NUT_PPS, tp1, lay, 8'($urandom));
    if ($urandom_range(0, 2) == 0) send_nal(NUT_PH, tp1, lay, 8'($urandom));
    repeat ($urandom_range(0, 2))
      send_nal($urandom_range(0, 1) ? NUT_PREFIX_SEI : NUT_PREFIX_APS, tp1, lay, 8'($urandom));
    n_sl = $urandom_range(1, 4);
    for (k = 0; k < n_sl; k++) begin
      sb = 8'($urandom);
      // Later slices mostly belong to the same picture.
      if (k != 0 && $urandom_range(0, 9) != 0) sb[PH_IN_SLICE_BIT] = 1'b0;
      send_nal(5'($urandom_range(0, NUT_VCL_LAST)), tp1, lay, sb);
      if ($urandom_range(0, 9) == 0) send_noise();
    end
    repeat ($urandom_range(0, 2))
      send_nal($urandom_range(0, 1) ? NUT_SUFFIX_SEI : NUT_SUFFIX_APS, tp1, lay, 8'($urandom));
    case ($urandom_range(0, 39))
      0:       send_nal(NUT_EOS, tp1, lay, 8'($urandom));
      1:       send_nal(NUT_EOB, tp1, lay, 8'($urandom));
      2, 3:    send_op(OP_FLUSH);
      4:       send_op(OP_RESET);
      5, 6:    send_nal(5'($urandom_range(NUT_RSV_FIRST, NUT_RSV_LAST)), tp1, lay, 8'($urandom));
      7:       send_nal($urandom_range(0, 1) ? NUT_OPI : NUT_DCI, tp1, lay, 8'($urandom));
      8, 9:    send_noise();
      default: begin
      end
    endcase
  endtask

  // Result side: random stalls, one long stall once the pipe is busy, none at the end.
  initial begin : result_sink
    int stall_pct;
    int iter;
    stall_pct = 10;
    iter      = 0;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      iter++;
      if (iter % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 10;
          default: stall_pct = 30;
        endcase
      end
      if (!long_hold_done && items_counted >= HOLD_AT_ITEM) begin
        // The input side keeps offering, so the queue fills and input ready drops.
        long_hold_done = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic report_field(input string name, input logic [1:0] want,
                              input logic [1:0] got);
    $display("%0t: mismatch in %s, expected %0d, got %0d", $time, name, want, got);
    mismatch_count++;
  endtask

  // Every result transaction is compared, field by field, with the oldest expectation.
  always @(posedge clk) begin : decision_check
    result_t got;
    result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = {out_chan.unit_action, out_chan.unit_p_mark, out_chan.unit_b_mark,
             out_chan.pending_merged, out_chan.nal_route, out_chan.nal_is_slice};
      if (expected_decisions.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, got %h", $time, got);
        mismatch_count++;
      end else begin
        want = expected_decisions.pop_front();
        if (got.unit_action !== want.unit_action)
          report_field("unit_action", want.unit_action, got.unit_action);
        if (got.unit_p_mark !== want.unit_p_mark)
          report_field("unit_p_mark", {1'b0, want.unit_p_mark}, {1'b0, got.unit_p_mark});
        if (got.unit_b_mark !== want.unit_b_mark)
          report_field("unit_b_mark", {1'b0, want.unit_b_mark}, {1'b0, got.unit_b_mark});
        if (got.pending_merged !== want.pending_merged)
          report_field("pending_merged", {1'b0, want.pending_merged},
                       {1'b0, got.pending_merged});
        if (got.nal_route !== want.nal_route)
          report_field("nal_route", want.nal_route, got.nal_route);
        if (got.nal_is_slice !== want.nal_is_slice)
          report_field("nal_is_slice", {1'b0, want.nal_is_slice}, {1'b0, got.nal_is_slice});
      end
    end
  end

  initial begin : stimulus
    stim_row_t directed_rows[$];
    result_t   quiet;
    int        i;
    quiet = '0;
    rst_n                <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.operation    <= OP_NAL;
    in_chan.too_short    <= 1'b0;
    in_chan.header_byte0 <= 8'h00;
    in_chan.header_byte1 <= 8'h00;
    in_chan.slice_byte0  <= 8'h00;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Rows with nothing typed in are checked against the predictor.
    // Short fragment with every header bit set, and an unknown operation: no effect.
    directed_rows.push_back(mk_row(OP_NAL, 1'b1, 8'hff, 8'hff, 8'hff, 1'b1, quiet));
    directed_rows.push_back(mk_row(OP_UNKNOWN, 1'b1, 8'hff, 8'hff, 8'hff, 1'b1, quiet));
    // Flush, reset and a forbidden-bit header with no unit open.
    directed_rows.push_back(mk_row(OP_FLUSH, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1, quiet));
    directed_rows.push_back(mk_row(OP_RESET, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1, quiet));
    directed_rows.push_back(mk_row(OP_NAL, 1'b0, 8'h80, 8'h00, 8'h00, 1'b1, quiet));
    // First slice on the top layer opens a unit headed by a slice.
    directed_rows.push_back(mk_row(OP_NAL, 1'b0, 8'h3f, {NUT_TRAIL, 3'd1}, 8'h00, 1'b1,
                                   result_t'{ACT_NONE, 1'b0, 1'b0, 1'b0, ROUTE_APPEND, 1'b1}));
    // New picture before any parameter sets: the unit is discarded.
    directed_rows.push_back(mk_row(OP_NAL, 1'b0, 8'h00, {NUT_VCL_LAST, 3'd7}, 8'h80, 1'b0, quiet));
    directed_rows.push_back(mk_row(OP_NAL, 1'b0, 8'h00, {NUT_VPS, 3'd1}, 8'h00, 1'b0, quiet));
    directed_rows.push_back(mk_row(OP_NAL, 1'b0, 8'h00, {NUT_SPS, 3'd1}, 8'h00, 1'b0, quiet));
    directed_rows.push_back(mk_row(OP_NAL, 1'b0, 8'h00, {NUT_PPS, 3'd1}, 8'h00, 1'b0, quiet));
    // High temporal id, then prefix units that are held after a slice.
    directed_rows.push_back(mk_row(OP_NAL, 1'b0, 8'h01, {NUT_TRAIL, 3'd3}, 8'h80, 1'b0, quiet));
    directed_rows.push_back(mk_row(OP_NAL, 1'b0, 8'h01, {NUT_PREFIX_SEI, 3'd3}, 8'h00, 1'b0, quiet));
    directed_rows.push_back(mk_row(OP_NAL, 1'b0, 8'h01, {NUT_PREFIX_APS, 3'd3}, 8'h00, 1'b0, quiet));
    // Picture boundary with a ready stream: emitted with B mark, held units merged.
    directed_rows.push_back(mk_row(OP_NAL, 1'b0, 8'h02, {NUT_TRAIL, 3'd1}, 8'h80, 1'b0, quiet));
    directed_rows.push_back(mk_row(OP_NAL, 1'b0, 8'h02, {NUT_SUFFIX_SEI, 3'd1}, 8'h00, 1'b0, quiet));
    directed_rows.push_back(mk_row(OP_NAL, 1'b0, 8'h02, {NUT_SUFFIX_APS, 3'd1}, 8'h00, 1'b0, quiet));
    directed_rows.push_back(mk_row(OP_NAL, 1'b0, 8'h00, {NUT_PH, 3'd7}, 8'h00, 1'b0, quiet));
    directed_rows.push_back(mk_row(OP_NAL, 1'b0, 8'h00, {NUT_AUD, 3'd2}, 8'h00, 1'b0, quiet));
    // Temporal id field of zero, then OPI and a reserved type.
    directed_rows.push_back(mk_row(OP_NAL, 1'b0, 8'h00, {NUT_TRAIL, 3'd0}, 8'h7f, 1'b0, quiet));
    directed_rows.push_back(mk_row(OP_NAL, 1'b0, 8'h00, {NUT_OPI, 3'd1}, 8'h00, 1'b0, quiet));
    directed_rows.push_back(mk_row(OP_NAL, 1'b0, 8'h00, {NUT_RSV_LAST, 3'd7}, 8'hff, 1'b0, quiet));
    // Slice plus held prefix, then flush: held units join and the unit is emitted.
    directed_rows.push_back(mk_row(OP_NAL, 1'b0, 8'h00, {NUT_TRAIL, 3'd1}, 8'h00, 1'b0, quiet));
    directed_rows.push_back(mk_row(OP_NAL, 1'b0, 8'h00, {NUT_PREFIX_SEI, 3'd1}, 8'h00, 1'b0, quiet));
    directed_rows.push_back(mk_row(OP_FLUSH, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, quiet));
    // End of sequence and end of bitstream always start a new unit.
    directed_rows.push_back(mk_row(OP_NAL, 1'b0, 8'h00, {NUT_EOS, 3'd1}, 8'h00, 1'b0, quiet));
    directed_rows.push_back(mk_row(OP_NAL, 1'b0, 8'h00, {NUT_EOB, 3'd1}, 8'h00, 1'b0, quiet));
    // Forbidden bit with a unit open and a unit held, then a stream reset.
    directed_rows.push_back(mk_row(OP_NAL, 1'b0, 8'h00, {NUT_TRAIL, 3'd1}, 8'h00, 1'b0, quiet));
    directed_rows.push_back(mk_row(OP_NAL, 1'b0, 8'h00, {NUT_PREFIX_SEI, 3'd1}, 8'h00, 1'b0, quiet));
    directed_rows.push_back(mk_row(OP_NAL, 1'b0, 8'hc0, 8'h00, 8'h00, 1'b0, quiet));
    directed_rows.push_back(mk_row(OP_RESET, 1'b0, 8'hff, 8'hff, 8'hff, 1'b0, quiet));
    for (i = 0; i < directed_rows.size(); i++) offer_item(directed_rows[i]);

    // Random part: mostly well-formed pictures with random content.
    while (items_counted < ITEM_TARGET) send_random_picture();
    in_chan.valid <= 1'b0;

    while (expected_decisions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d NAL, flush and reset transactions through the splitter.",
             items_counted);
    $display("Access units emitted %0d, discarded %0d; NAL units held %0d.",
             units_emitted, units_discarded, nals_held);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### vvc_access_unit_splitter_core.f
+incdir+rtl/core
rtl/core/vvc_aus_pkg.sv
rtl/core/vvc_aus_ifs.sv
rtl/core/vvc_aus_front.sv
rtl/core/vvc_aus_queue.sv
rtl/core/vvc_aus_back.sv
rtl/core/vvc_access_unit_splitter_core.sv
test/tb.sv
